// File: hdl/mpd_pkg.sv
`default_nettype none

package mpd_pkg;

    // Fixed field widths of the stream payload
    localparam int GROUP_W = 4;
    localparam int POS_W   = 12;
    localparam int DIST_W  = 12;

    localparam logic [DIST_W-1:0] DIST_RESET = 12'd8;

    localparam int MAX_KEPT_DEFAULT   = 64;
    localparam int COORD_BITS_DEFAULT = 12;

    // Packed widths on the streams
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    // Positions in the output tuser
    localparam int USER_KEPT = 0;
    localparam int USER_OVF  = 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DECIDE
    } state_t;

endpackage

`default_nettype wire

// File: hdl/mpd_store.sv
`default_nettype none

module mpd_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 28
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/match_proximity_dedup.sv
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         tuser: new_frame; tdata: group_id, pos_x, pos_y
// m_axis    out        tuser: kept, overflow; tdata: out_group, out_x, out_y
// cfg       in         cfg_data: min_distance
//
// An item is scanned against the N entries kept so far in the current frame
// (at most MAX_KEPT) and then decided; an item that starts a new frame or meets
// an empty table goes straight to the decision. The kept table has one
// read port and the scan reads one stored entry per cycle through a single
// compare unit.
// Reset clears the entry count and sets min_distance to 8; the table itself
// needs no clearing pass, as only entries below the count are read.
// A finished result waits in the output register while the next item is taken
// and scanned; that item's decision holds until the output register is free.

module match_proximity_dedup #(
    parameter int MAX_KEPT   = mpd_pkg::MAX_KEPT_DEFAULT,
    parameter int COORD_BITS = mpd_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] group_id, [15:4] pos_x, [27:16] pos_y, [31:28] zero
    input  wire logic [mpd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] new_frame
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [3:0] out_group, [15:4] out_x, [27:16] out_y, [31:28] zero
    output logic [mpd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] kept, [1] overflow
    output logic [mpd_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mpd_pkg::DIST_W-1:0]     cfg_data
);

    localparam int GW  = mpd_pkg::GROUP_W;
    localparam int PW  = mpd_pkg::POS_W;
    localparam int DW  = mpd_pkg::DIST_W;
    localparam int ODW = mpd_pkg::OUT_DATA_W;
    localparam int CB  = (COORD_BITS < PW) ? COORD_BITS : PW;
    localparam int EW  = GW + 2 * CB;
    localparam int AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW  = $clog2(MAX_KEPT + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_KEPT);

    mpd_pkg::state_t state_reg, state_next;

    logic [DW-1:0] min_dist_reg, min_dist_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic          hit_reg, hit_next;
    logic [GW-1:0] grp_reg, grp_next;
    logic [PW-1:0] x_reg, x_next;
    logic [PW-1:0] y_reg, y_next;

    logic                            out_vld_reg, out_vld_next;
    logic [mpd_pkg::OUT_USER_W-1:0]  out_user_reg, out_user_next;
    logic [ODW-1:0]                  out_data_reg, out_data_next;

    logic          in_xfer;
    logic          scan_last;
    logic          out_free;
    logic          commit;
    logic          store;
    logic          rd_en;
    logic [EW-1:0] rd_data;
    logic [EW-1:0] wr_data;
    logic          match;
    logic [GW-1:0] ent_grp;
    logic [CB-1:0] ent_x;
    logic [CB-1:0] ent_y;
    logic [CB-1:0] cand_x;
    logic [CB-1:0] cand_y;
    logic [CB-1:0] dx;
    logic [CB-1:0] dy;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign scan_last = ((CW'(idx_reg) + CW'(1)) == cnt_reg);
    assign out_free  = !out_vld_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    // Shared compare unit: one stored entry against the held candidate
    assign ent_grp = rd_data[GW-1:0];
    assign ent_x   = rd_data[GW+CB-1:GW];
    assign ent_y   = rd_data[EW-1:GW+CB];
    assign cand_x  = x_reg[CB-1:0];
    assign cand_y  = y_reg[CB-1:0];
    assign dx      = (ent_x > cand_x) ? (ent_x - cand_x) : (cand_x - ent_x);
    assign dy      = (ent_y > cand_y) ? (ent_y - cand_y) : (cand_y - ent_y);
    assign match   = (ent_grp == grp_reg) && (DW'(dx) < min_dist_reg)
                     && (DW'(dy) < min_dist_reg);

    assign store   = commit && !hit_reg && (cnt_reg < CNT_MAX);
    assign wr_data = {cand_y, cand_x, grp_reg};

    mpd_store #(
        .DEPTH (MAX_KEPT),
        .AW    (AW),
        .DW    (EW)
    ) u_store (
        .clk     (clk),
        .wr_en   (store),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpd_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser || (cnt_reg == '0))
                    begin
                        state_next = mpd_pkg::ST_DECIDE;
                    end
                    else
                    begin
                        state_next = mpd_pkg::ST_SCAN;
                    end
                end
            end
            mpd_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = mpd_pkg::ST_LAST;
                end
            end
            mpd_pkg::ST_LAST:
            begin
                state_next = mpd_pkg::ST_DECIDE;
            end
            mpd_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = mpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpd_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        commit        = 1'b0;
        unique case (state_reg)
            mpd_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            mpd_pkg::ST_SCAN:   rd_en = 1'b1;
            mpd_pkg::ST_LAST:   rd_en = 1'b0;
            mpd_pkg::ST_DECIDE: commit = out_free;
            default:            rd_en = 1'b0;
        endcase
    end

    // Datapath
    always_comb
    begin
        min_dist_next = min_dist_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        grp_next      = grp_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        out_vld_next  = out_vld_reg;
        out_user_next = out_user_reg;
        out_data_next = out_data_reg;

        pend_next = rd_en;
        hit_next  = hit_reg || (pend_reg && match);

        if (cfg_valid && cfg_ready)
        begin
            min_dist_next = cfg_data;
        end

        if (in_xfer)
        begin
            grp_next = s_axis_tdata[GW-1:0];
            x_next   = s_axis_tdata[GW+PW-1:GW];
            y_next   = s_axis_tdata[GW+2*PW-1:GW+PW];
            idx_next = '0;
            hit_next = 1'b0;
            if (s_axis_tuser)
            begin
                cnt_next = '0;
            end
        end
        else if (rd_en)
        begin
            idx_next = idx_reg + AW'(1);
        end

        if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        if (commit)
        begin
            out_vld_next = 1'b1;
            out_user_next[mpd_pkg::USER_KEPT] = store;
            out_user_next[mpd_pkg::USER_OVF]  = !hit_reg && (cnt_reg >= CNT_MAX);
            out_data_next = ODW'({y_reg, x_reg, grp_reg});
            if (store)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mpd_pkg::ST_IDLE;
            min_dist_reg <= mpd_pkg::DIST_RESET;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            min_dist_reg <= min_dist_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg      <= grp_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        out_user_reg <= out_user_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = out_data_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[mpd_pkg::USER_KEPT]
                            && m_axis_tuser[mpd_pkg::USER_OVF]))
        else $error("kept and overflow both set");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("entry count beyond table depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpd_pkg::ST_SCAN) |-> (CW'(idx_reg) < cnt_reg))
        else $error("scan reads an entry that was never written");

    a_store_counts: assert property (@(posedge clk) disable iff (!rst_n)
        store |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("stored entry not counted");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (m_axis_tvalid
                    && (m_axis_tuser[mpd_pkg::USER_KEPT] == $past(store))))
        else $error("decision not shown on the output");

endmodule

`default_nettype wire

// File: tb/mpd_dedup_checker.sv
`timescale 1ns / 100ps

module mpd_dedup_checker
    import mpd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    input  wire logic                    s_axis_tready,
    // [3:0] group_id, [15:4] pos_x, [27:16] pos_y, [31:28] zero
    input  wire logic [IN_DATA_W-1:0]    s_axis_tdata,
    // [0] new_frame
    input  wire logic                    s_axis_tuser,
    input  wire logic                    m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // [3:0] out_group, [15:4] out_x, [27:16] out_y, [31:28] zero
    input  wire logic [OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] kept, [1] overflow
    input  wire logic [OUT_USER_W-1:0]   m_axis_tuser,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_ready,
    input  wire logic [DIST_W-1:0]       cfg_data,
    input  wire logic                    drain_done,
    output int                           pending,
    output int                           failures
);

    localparam int TABLE_DEPTH = MAX_KEPT_DEFAULT;
    localparam int COORD_MASK  = (1 << COORD_BITS_DEFAULT) - 1;

    typedef struct packed {
        logic               kept;
        logic               overflow;
        logic [GROUP_W-1:0] grp;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
    } verdict_t;

    typedef struct packed {
        logic [GROUP_W-1:0] grp;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
    } survivor_t;

    survivor_t         survivors [TABLE_DEPTH];
    int                survivor_count;
    logic [DIST_W-1:0] proximity;
    verdict_t          expected_verdicts [$];
    bit                drained;

    // Greedy first-wins decision: a candidate near an earlier survivor of its group is dropped
    function automatic verdict_t judge_candidate(
        input logic               nf,
        input logic [GROUP_W-1:0] g,
        input logic [POS_W-1:0]   ex,
        input logic [POS_W-1:0]   ey
    );
        verdict_t v;
        int       x;
        int       y;
        int       dx;
        int       dy;
        bit       dup;
        x   = int'(ex) & COORD_MASK;
        y   = int'(ey) & COORD_MASK;
        dup = 1'b0;
        if (nf)
            survivor_count = 0;
        for (int k = 0; k < survivor_count; k++)
        begin
            dx = (x > int'(survivors[k].x)) ? x - int'(survivors[k].x) : int'(survivors[k].x) - x;
            dy = (y > int'(survivors[k].y)) ? y - int'(survivors[k].y) : int'(survivors[k].y) - y;
            if (survivors[k].grp == g && dx < int'(proximity) && dy < int'(proximity))
                dup = 1'b1;
        end
        v.kept     = 1'b0;
        v.overflow = 1'b0;
        v.grp      = g;
        v.x        = ex;
        v.y        = ey;
        if (!dup)
        begin
            if (survivor_count < TABLE_DEPTH)
            begin
                survivors[survivor_count] = '{grp: g, x: POS_W'(x), y: POS_W'(y)};
                survivor_count++;
                v.kept = 1'b1;
            end
            else
            begin
                v.overflow = 1'b1;
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        verdict_t fresh;
        if (!rst_n)
        begin
            survivor_count = 0;
            proximity      = DIST_RESET;
            expected_verdicts.delete();
            drained        = 1'b0;
            failures       = 0;
            pending        = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                proximity = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                fresh = judge_candidate(s_axis_tuser, s_axis_tdata[3:0],
                                        s_axis_tdata[15:4], s_axis_tdata[27:16]);
                expected_verdicts.insert(expected_verdicts.size(), fresh);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("result transfer with no candidate pending: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    failures++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (m_axis_tuser[USER_KEPT] !== want.kept)
                    begin
                        $error("kept: expected %0d, got %0d", want.kept, m_axis_tuser[USER_KEPT]);
                        failures++;
                    end
                    if (m_axis_tuser[USER_OVF] !== want.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d", want.overflow,
                               m_axis_tuser[USER_OVF]);
                        failures++;
                    end
                    if (m_axis_tdata[3:0] !== want.grp)
                    begin
                        $error("out_group: expected %0d, got %0d", want.grp, m_axis_tdata[3:0]);
                        failures++;
                    end
                    if (m_axis_tdata[15:4] !== want.x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.x, m_axis_tdata[15:4]);
                        failures++;
                    end
                    if (m_axis_tdata[27:16] !== want.y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.y, m_axis_tdata[27:16]);
                        failures++;
                    end
                end
            end
            // Anything still queued once the run has drained never came out
            if (drain_done && !drained)
            begin
                drained = 1'b1;
                if (expected_verdicts.size() != 0)
                begin
                    $error("%0d results never arrived", expected_verdicts.size());
                    failures += expected_verdicts.size();
                end
            end
            pending = expected_verdicts.size();
        end
    end

endmodule

// File: tb/match_proximity_dedup_tb.sv
`timescale 1ns / 100ps

module match_proximity_dedup_tb;

    import mpd_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [DIST_W-1:0]     cfg_data;
    logic                  drain_done;
    int                    pending;
    int                    failures;

    logic [DIST_W-1:0]     cur_min_dist;
    int                    candidates_sent;
    bit                    steady_in;
    bit                    squeeze_done;

    match_proximity_dedup u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    mpd_dedup_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .drain_done    (drain_done),
        .pending       (pending),
        .failures      (failures)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #15_000_000;
        $display("match_proximity_dedup_tb: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady_in)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Land near a stored position so both sides of the threshold get hit
    function automatic logic [POS_W-1:0] jitter(input logic [POS_W-1:0] c);
        int span;
        int v;
        span = int'(cur_min_dist) + 1;
        if (span > 4095)
            span = 4095;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return POS_W'(v);
    endfunction

    task automatic offer_candidate(
        input logic               nf,
        input logic [GROUP_W-1:0] g,
        input logic [POS_W-1:0]   x,
        input logic [POS_W-1:0]   y
    );
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nf;
        s_axis_tdata  <= {4'b0, y, x, g};
        do @(posedge clk); while (!s_axis_tready);
        candidates_sent++;
    endtask

    // Step past the last transfer first so the checker has counted it
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_min_distance(input logic [DIST_W-1:0] value);
        drain();
        repeat (70) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        cur_min_dist = value;
    endtask

    // Frames of random length; about half of the candidates sit near earlier ones in the frame
    task automatic run_frames(input int count);
        logic [GROUP_W-1:0] ag [8];
        logic [POS_W-1:0]   ax [8];
        logic [POS_W-1:0]   ay [8];
        logic [GROUP_W-1:0] g;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic               nf;
        int                 left;
        int                 frame_len;
        int                 n_anchor;
        int                 k;
        int                 r;
        left = count;
        while (left > 0)
        begin
            frame_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 40)
                                                     : $urandom_range(60, 90);
            steady_in = ($urandom_range(0, 3) == 0);
            n_anchor  = 0;
            for (int i = 0; i < frame_len && left > 0; i++)
            begin
                nf = (i == 0) || ($urandom_range(0, 99) < 3);
                r  = $urandom_range(0, 99);
                if (n_anchor > 0 && r < 50)
                begin
                    k = $urandom_range(0, n_anchor - 1);
                    g = (r < 5) ? GROUP_W'($urandom_range(0, 15)) : ag[k];
                    x = (r < 15) ? ax[k] : jitter(ax[k]);
                    y = (r < 15) ? ay[k] : jitter(ay[k]);
                end
                else
                begin
                    g = (r < 75) ? GROUP_W'($urandom_range(0, 3))
                                 : GROUP_W'($urandom_range(0, 15));
                    x = POS_W'($urandom_range(0, 4095));
                    y = POS_W'($urandom_range(0, 4095));
                    k = (n_anchor < 8) ? n_anchor : $urandom_range(0, 7);
                    ag[k] = g;
                    ax[k] = x;
                    ay[k] = y;
                    if (n_anchor < 8)
                        n_anchor++;
                end
                offer_candidate(nf, g, x, y);
                left--;
            end
        end
        steady_in = 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off to back the block up
    initial
    begin
        int r;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!squeeze_done && candidates_sent >= 150)
            begin
                squeeze_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            r = $urandom_range(0, 99);
            m_axis_tready <= 1'b1;
            repeat ((r < 20) ? $urandom_range(50, 200) : $urandom_range(1, 12)) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r >= 30)
            begin
                m_axis_tready <= 1'b0;
                repeat ((r < 90) ? $urandom_range(1, 3) : $urandom_range(15, 60)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int waited;
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        drain_done      = 1'b0;
        cur_min_dist    = DIST_RESET;
        candidates_sent = 0;
        steady_in       = 1'b0;
        squeeze_done    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Threshold at its reset value: edges of the window, groups, coordinate extremes
        offer_candidate(1'b1, 4'd0,  12'd0,    12'd0);
        offer_candidate(1'b0, 4'd0,  12'd7,    12'd7);
        offer_candidate(1'b0, 4'd0,  12'd8,    12'd0);
        offer_candidate(1'b0, 4'd0,  12'd0,    12'd8);
        offer_candidate(1'b0, 4'd1,  12'd0,    12'd0);
        offer_candidate(1'b0, 4'd15, 12'd4095, 12'd4095);
        offer_candidate(1'b0, 4'd15, 12'd4088, 12'd4088);
        offer_candidate(1'b0, 4'd15, 12'd4087, 12'd4095);
        offer_candidate(1'b0, 4'd15, 12'd4095, 12'd0);
        offer_candidate(1'b0, 4'd15, 12'd0,    12'd4095);
        offer_candidate(1'b1, 4'd0,  12'd7,    12'd7);
        offer_candidate(1'b0, 4'd0,  12'd0,    12'd0);
        offer_candidate(1'b0, 4'd10, 12'd2730, 12'd1365);

        // Fill the table, overflow it, then hit a stored entry while full
        for (int i = 0; i < 66; i++)
            offer_candidate(i == 0, 4'd5, POS_W'(i * 16), 12'd100);
        offer_candidate(1'b0, 4'd5, 12'd3, 12'd101);
        run_frames(380);

        // Zero threshold: nothing is a duplicate
        write_min_distance(12'd0);
        offer_candidate(1'b1, 4'd5, 12'd100, 12'd100);
        offer_candidate(1'b0, 4'd5, 12'd100, 12'd100);
        run_frames(240);

        write_min_distance(12'd4095);
        offer_candidate(1'b1, 4'd3, 12'd0,    12'd0);
        offer_candidate(1'b0, 4'd3, 12'd4095, 12'd4095);
        offer_candidate(1'b0, 4'd3, 12'd4094, 12'd4094);
        run_frames(200);

        write_min_distance(12'd1);
        offer_candidate(1'b1, 4'd7, 12'd50, 12'd50);
        offer_candidate(1'b0, 4'd7, 12'd50, 12'd50);
        offer_candidate(1'b0, 4'd7, 12'd51, 12'd50);
        run_frames(300);

        write_min_distance(DIST_W'($urandom_range(2, 64)));
        run_frames(400);

        write_min_distance(DIST_W'($urandom_range(65, 4094)));
        run_frames(400);

        s_axis_tvalid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (70) @(posedge clk);
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);
        if (failures == 0)
            $display("match_proximity_dedup_tb: done, clean");
        else
            $display("match_proximity_dedup_tb: done, errors");
        $finish;
    end

endmodule
